// ===== hdl/assert_macros.svh =====
// assertion helpers for the route table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

    localparam int KIND_W = 2;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int REM_W  = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NEXT    = 2'd3
    } t_kind;

    // strobes broadcast from the sequencer to every cell
    typedef struct packed {
        logic compare;  // latch compare flags
        logic walk;     // select by cursor position instead of key match
        logic update;   // overwrite data of the matching cell
        logic insert;   // open a slot for a new key, shift the upper part
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/srt_ifs.sv =====
`default_nettype none

interface srt_in_if;
    logic                         valid;
    logic                         ready;
    logic [srt_pkg::KIND_W-1:0]   kind;
    logic [srt_pkg::KEY_W-1:0]    dest_key;
    logic [srt_pkg::DATA_W-1:0]   entry_data;

    modport source (output valid, kind, dest_key, entry_data, input ready);
    modport sink   (input valid, kind, dest_key, entry_data, output ready);
endinterface

interface srt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         table_full;
    logic                         walk_end;
    logic [srt_pkg::KEY_W-1:0]    out_key;
    logic [srt_pkg::DATA_W-1:0]   out_data;
    logic [srt_pkg::REM_W-1:0]    remaining;

    modport source (output valid, found, table_full, walk_end, out_key, out_data, remaining,
                    input ready);
    modport sink   (input valid, found, table_full, walk_end, out_key, out_data, remaining,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_key_route_table.sv =====
// channel   dir   modport   payload
// i_in      in    sink      kind, dest_key, entry_data
// o_out     out   source    found, table_full, walk_end, out_key, out_data, remaining
//
// one transaction at a time: accept, compare, gather, finish; compare and gather
// pass through the cell compare register and the two-level registered select tree
// the result register frees the input side: the next transaction is taken while
// a finished result still waits on o_out
// i_rst_n is synchronous, active low, and clears count, cursor and control state;
// the key and data cells hold no reset value
`default_nettype none
`include "assert_macros.svh"

module sorted_key_route_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    srt_in_if.sink     i_in,
    srt_out_if.source  o_out
);

    // stored widths: keys are never wider than the key field
    localparam int KW = (KEY_BITS < srt_pkg::KEY_W) ? KEY_BITS : srt_pkg::KEY_W;
    localparam int DW = (DATA_BITS < srt_pkg::DATA_W) ? DATA_BITS : srt_pkg::DATA_W;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CMP    = 4'b0010,
        ST_GATHER = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    srt_pkg::t_kind              r_kind;
    logic [KW-1:0]               r_key;
    logic [DW-1:0]               r_data;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_cursor, n_cursor;

    // result register
    logic                        r_o_valid;
    logic                        r_found, n_found;
    logic                        r_full, n_full;
    logic                        r_wend, n_wend;
    logic [srt_pkg::KEY_W-1:0]   r_okey, n_okey;
    logic [srt_pkg::DATA_W-1:0]  r_odata, n_odata;
    logic [srt_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [CW-1:0]               rem_full;

    logic                        in_take;
    logic                        leave_done;
    srt_pkg::t_cell_cmd          cell_cmd;

    // cell row
    logic [KW-1:0]               c_key  [TABLE_DEPTH];
    logic [DW-1:0]               c_data [TABLE_DEPTH];
    logic                        c_le   [TABLE_DEPTH];
    logic                        c_gt   [TABLE_DEPTH];
    logic                        c_sel  [TABLE_DEPTH];

    logic                        g_hit;
    logic [KW-1:0]               g_key;
    logic [DW-1:0]               g_data;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    // finish only when the result register is free or being emptied
    assign leave_done = (r_state == ST_DONE) && (!r_o_valid || o_out.ready);

    // data write strobes fire once, on the cycle that finishes the transaction
    always_comb begin
        cell_cmd.compare = (r_state == ST_CMP);
        cell_cmd.walk    = (r_kind == srt_pkg::KIND_NEXT);
        cell_cmd.update  = leave_done && (r_kind == srt_pkg::KIND_INSERT) && g_hit;
        cell_cmd.insert  = leave_done && (r_kind == srt_pkg::KIND_INSERT) && !g_hit
                           && (r_count < DEPTH_C);
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [KW-1:0] left_key;
        logic [DW-1:0] left_data;
        logic          left_le;
        logic          left_gt;

        if (i == 0) begin : g_first
            // nothing below the first cell: a new smallest key lands here
            assign left_key  = '0;
            assign left_data = '0;
            assign left_le   = 1'b1;
            assign left_gt   = 1'b0;
        end else begin : g_rest
            assign left_key  = c_key[i-1];
            assign left_data = c_data[i-1];
            assign left_le   = c_le[i-1];
            assign left_gt   = c_gt[i-1];
        end

        srt_cell #(
            .KW  (KW),
            .DW  (DW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cell_cmd),
            .i_count     (r_count),
            .i_cursor    (r_cursor),
            .i_key       (r_key),
            .i_data      (r_data),
            .i_left_key  (left_key),
            .i_left_data (left_data),
            .i_left_le   (left_le),
            .i_left_gt   (left_gt),
            .o_key       (c_key[i]),
            .o_data      (c_data[i]),
            .o_le        (c_le[i]),
            .o_gt        (c_gt[i]),
            .o_sel       (c_sel[i])
        );
    end

    // selected entry (key match or cursor position) collected over two levels
    srt_gather #(
        .N  (TABLE_DEPTH),
        .KW (KW),
        .DW (DW)
    ) u_gather (
        .i_clk  (i_clk),
        .i_en   (r_state == ST_GATHER),
        .i_sel  (c_sel),
        .i_key  (c_key),
        .i_data (c_data),
        .o_hit  (g_hit),
        .o_key  (g_key),
        .o_data (g_data)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_take) n_state = ST_CMP;
            ST_CMP:    n_state = ST_GATHER;
            ST_GATHER: n_state = ST_DONE;
            ST_DONE:   if (leave_done) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // result and bookkeeping for the finishing transaction
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_found  = 1'b0;
        n_full   = 1'b0;
        n_wend   = 1'b0;
        n_okey   = '0;
        n_odata  = '0;
        case (r_kind)
            srt_pkg::KIND_INSERT: begin
                n_found = g_hit;
                if (!g_hit) begin
                    if (r_count < DEPTH_C) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        // new key with no room left: dropped
                        n_full = 1'b1;
                    end
                end
            end
            srt_pkg::KIND_LOOKUP: begin
                n_found = g_hit;
                n_okey  = srt_pkg::KEY_W'(g_key);
                n_odata = srt_pkg::DATA_W'(g_data);
            end
            srt_pkg::KIND_RESTART: begin
                n_cursor = '0;
            end
            srt_pkg::KIND_NEXT: begin
                if (r_cursor >= r_count) begin
                    // walk past the end: cursor stays put
                    n_wend = 1'b1;
                end else begin
                    n_okey   = srt_pkg::KEY_W'(g_key);
                    n_odata  = srt_pkg::DATA_W'(g_data);
                    n_cursor = r_cursor + 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        rem_full = n_count - n_cursor;
        n_rem    = srt_pkg::REM_W'(rem_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (leave_done) begin
                r_count   <= n_count;
                r_cursor  <= n_cursor;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // captured request and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= srt_pkg::t_kind'(i_in.kind);
            r_key  <= KW'(i_in.dest_key);
            r_data <= DW'(i_in.entry_data);
        end
        if (leave_done) begin
            r_found <= n_found;
            r_full  <= n_full;
            r_wend  <= n_wend;
            r_okey  <= n_okey;
            r_odata <= n_odata;
            r_rem   <= n_rem;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.found      = r_found;
    assign o_out.table_full = r_full;
    assign o_out.walk_end   = r_wend;
    assign o_out.out_key    = r_okey;
    assign o_out.out_data   = r_odata;
    assign o_out.remaining  = r_rem;

    // the walk never runs ahead of the fill level
    `ASSERT_ALWAYS(a_cursor_in_range, i_clk, i_rst_n, r_cursor <= r_count)
    // the fill level never exceeds the cell row
    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= DEPTH_C)
    // a dropped insert is only reported with every cell in use
    `ASSERT_IMPLY(a_full_only_when_full, i_clk, i_rst_n, r_o_valid && r_full, r_count == DEPTH_C)
    // a walk end is only reported with nothing left to walk
    `ASSERT_IMPLY(a_wend_nothing_left, i_clk, i_rst_n, r_o_valid && r_wend, r_cursor == r_count)
    // a new key grows the table by exactly one
    `ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, cell_cmd.insert, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

// ===== hdl/srt_cell.sv =====
`default_nettype none

module srt_cell #(
    parameter int KW  = 32,
    parameter int DW  = 64,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  wire logic               i_clk,
    input  wire srt_pkg::t_cell_cmd i_cmd,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic [CW-1:0]      i_cursor,
    input  wire logic [KW-1:0]      i_key,
    input  wire logic [DW-1:0]      i_data,
    input  wire logic [KW-1:0]      i_left_key,
    input  wire logic [DW-1:0]      i_left_data,
    input  wire logic               i_left_le,
    input  wire logic               i_left_gt,
    output logic      [KW-1:0]      o_key,
    output logic      [DW-1:0]      o_data,
    output logic                    o_le,
    output logic                    o_gt,
    output logic                    o_sel
);

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [KW-1:0] r_key;
    logic [DW-1:0] r_data;
    logic          r_le;
    logic          r_gt;
    logic          r_sel;
    logic          occupied;

    assign occupied = (POS < i_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_le  <= occupied && (r_key <= i_key);
            r_gt  <= occupied && (r_key > i_key);
            r_sel <= i_cmd.walk ? (occupied && (POS == i_cursor))
                                : (occupied && (r_key == i_key));
        end
        if (i_cmd.insert) begin
            if (i_left_gt) begin
                // upper part moves up one place
                r_key  <= i_left_key;
                r_data <= i_left_data;
            end else if (i_left_le && !r_le) begin
                // first slot above all smaller keys
                r_key  <= i_key;
                r_data <= i_data;
            end
        end else if (i_cmd.update && r_sel) begin
            r_data <= i_data;
        end
    end

    assign o_key  = r_key;
    assign o_data = r_data;
    assign o_le   = r_le;
    assign o_gt   = r_gt;
    assign o_sel  = r_sel;

endmodule

`default_nettype wire

// ===== hdl/srt_gather.sv =====
`default_nettype none

module srt_gather #(
    parameter int N  = 64,
    parameter int KW = 32,
    parameter int DW = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_sel  [N],
    input  wire logic [KW-1:0] i_key  [N],
    input  wire logic [DW-1:0] i_data [N],
    output logic               o_hit,
    output logic      [KW-1:0] o_key,
    output logic      [DW-1:0] o_data
);

    localparam int GS = 8;
    localparam int NG = (N + GS - 1) / GS;

    logic          r_ghit  [NG];
    logic [KW-1:0] r_gkey  [NG];
    logic [DW-1:0] r_gdata [NG];
    logic          n_ghit  [NG];
    logic [KW-1:0] n_gkey  [NG];
    logic [DW-1:0] n_gdata [NG];

    // first level: or of the selected entries within each group of eight
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_ghit[g]  = 1'b0;
            n_gkey[g]  = '0;
            n_gdata[g] = '0;
            for (int k = 0; k < GS; k++) begin
                if (g * GS + k < N) begin
                    n_ghit[g]  = n_ghit[g] | i_sel[g * GS + k];
                    n_gkey[g]  = n_gkey[g] | ({KW{i_sel[g * GS + k]}} & i_key[g * GS + k]);
                    n_gdata[g] = n_gdata[g] | ({DW{i_sel[g * GS + k]}} & i_data[g * GS + k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ghit  <= n_ghit;
            r_gkey  <= n_gkey;
            r_gdata <= n_gdata;
        end
    end

    // second level: or across the registered groups
    always_comb begin
        o_hit  = 1'b0;
        o_key  = '0;
        o_data = '0;
        for (int g = 0; g < NG; g++) begin
            o_hit  = o_hit | r_ghit[g];
            o_key  = o_key | r_gkey[g];
            o_data = o_data | r_gdata[g];
        end
    end

endmodule

`default_nettype wire
